// ===== rtl/dsra_pkg.sv =====
package dsra_pkg;

    localparam int DSRA_WINDOW_DEPTH = 8;
    localparam int VAL_W             = 10;
    localparam int RAW_W             = 16;
    localparam int STAT_W            = 8;
    localparam int DIST_W            = 11;
    localparam int CFG_IDX_W         = 8;

    // x / 10 == (x * 52429) >> 19 for any 16-bit x
    localparam int                RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_TEN  = 16'd52429;
    localparam int                RECIP_SHIFT = 19;
    localparam int                CM_W        = RAW_W + RECIP_W - RECIP_SHIFT;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DIST  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIM  = 8'd3;

    localparam logic [VAL_W-1:0] RST_MAX_DIST  = 10'd400;
    localparam logic [VAL_W-1:0] RST_STOP_DIST = 10'd15;
    localparam logic [VAL_W-1:0] RST_SLOW_DIST = 10'd30;
    localparam logic [VAL_W-1:0] RST_SPIKE_LIM = 10'd50;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    typedef struct packed {
        logic in_rdy;
        logic conv;
        logic upd;
        logic div_take;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_acc;
        logic take;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/dsra_ifs.sv =====
interface dsra_in_if
    import dsra_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              data_ready;
    logic              timed_out;
    logic [STAT_W-1:0] meas_status;
    logic [RAW_W-1:0]  raw_mm;

    modport source (output valid, data_ready, timed_out, meas_status, raw_mm, input ready);
    modport sink   (input valid, data_ready, timed_out, meas_status, raw_mm, output ready);
endinterface

interface dsra_out_if
    import dsra_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance_cm;
    logic                     obstacle_close;
    logic                     obstacle_near;
    logic                     spike_rejected;
    logic                     sample_accepted;

    modport source (output valid, distance_cm, obstacle_close, obstacle_near,
                    spike_rejected, sample_accepted, input ready);
    modport sink   (input valid, distance_cm, obstacle_close, obstacle_near,
                    spike_rejected, sample_accepted, output ready);
endinterface

interface dsra_cfg_if
    import dsra_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dsra_div.sv =====
module dsra_div
    import dsra_pkg::*;
#(
    parameter int SUM_W  = 13,
    parameter int FILL_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [FILL_W-1:0] i_divisor,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [FILL_W-1:0] r_rem, n_rem;
    logic [FILL_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [FILL_W:0]   shifted;
    logic [FILL_W:0]   diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = diff[FILL_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[FILL_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[VAL_W-1:0];

endmodule

// ===== rtl/dsra_dp.sv =====
module dsra_dp
    import dsra_pkg::*;
#(
    parameter int WINDOW_DEPTH = DSRA_WINDOW_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dsra_in_if.sink           i_in,
    dsra_out_if.source        o_out,
    dsra_cfg_if.sink          i_cfg,
    input  t_cmd              i_cmd,
    output t_sts              o_sts
);

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = $clog2(WINDOW_DEPTH * 1023 + 1);

    logic [VAL_W-1:0]  r_max_dist, r_stop_dist, r_slow_dist, r_spike_lim;

    logic              r_usable;
    logic [RAW_W-1:0]  r_raw;
    logic [CM_W-1:0]   r_cm;
    logic [RAW_W+RECIP_W-1:0] prod;

    logic [VAL_W-1:0]  r_store [WINDOW_DEPTH];
    logic [VAL_W-1:0]  r_old;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [VAL_W-1:0]  r_last;
    logic              r_has;
    logic              r_spike, r_acc;

    logic [VAL_W-1:0]  cm_clamp;
    logic [VAL_W-1:0]  abs_diff;
    logic              spike;
    logic              take;
    logic              full;
    logic [VAL_W-1:0]  old_val;

    logic              div_done;
    logic [VAL_W-1:0]  quotient;

    logic                     r_o_valid;
    logic signed [DIST_W-1:0] r_o_dist;
    logic                     r_o_close, r_o_near, r_o_spike, r_o_acc;

    // configuration
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist  <= RST_MAX_DIST;
            r_stop_dist <= RST_STOP_DIST;
            r_slow_dist <= RST_SLOW_DIST;
            r_spike_lim <= RST_SPIKE_LIM;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MAX_DIST:  r_max_dist  <= i_cfg.data;
                CFG_STOP_DIST: r_stop_dist <= i_cfg.data;
                CFG_SLOW_DIST: r_slow_dist <= i_cfg.data;
                CFG_SPIKE_LIM: r_spike_lim <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input capture and mm to cm
    assign i_in.ready    = i_cmd.in_rdy && i_rst_n;
    assign o_sts.in_acc  = i_in.valid && i_in.ready;

    assign prod = r_raw * RECIP_TEN;

    always_ff @(posedge i_clk) begin
        if (o_sts.in_acc) begin
            r_usable <= i_in.data_ready && !i_in.timed_out && (i_in.meas_status == '0);
            r_raw    <= i_in.raw_mm;
        end
        if (i_cmd.conv) begin
            r_cm <= prod[RAW_W+RECIP_W-1:RECIP_SHIFT];
        end
    end

    // clamp, spike test, window update
    always_comb begin
        cm_clamp = (r_cm > CM_W'(r_max_dist)) ? r_max_dist : r_cm[VAL_W-1:0];
        abs_diff = (cm_clamp > r_last) ? cm_clamp - r_last : r_last - cm_clamp;
        spike    = r_has && (r_last != '0) && (abs_diff > r_spike_lim);
        take     = r_usable && !spike;
        full     = (r_fill == FILL_W'(WINDOW_DEPTH));
        old_val  = full ? r_old : '0;
        n_sum    = r_sum - SUM_W'(old_val) + SUM_W'(cm_clamp);
        n_fill   = full ? r_fill : r_fill + 1'b1;
        n_pos    = (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
    end

    assign o_sts.take = take;

    // entry to be replaced is read during conversion
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && take) begin
            r_store[r_pos] <= cm_clamp;
        end
        if (i_cmd.conv) begin
            r_old <= r_store[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_last <= '0;
            r_has  <= 1'b0;
        end else begin
            if (i_cmd.upd && take) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (i_cmd.div_take) begin
                r_last <= quotient;
                r_has  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_spike <= r_usable && spike;
            r_acc   <= take;
        end
    end

    dsra_div #(
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.upd && take),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_sts.div_done = div_done;

    // output register
    assign o_sts.out_free = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_dist  <= r_has ? DIST_W'({1'b0, r_last}) : DIST_NONE;
            r_o_close <= r_has && (r_last <= r_stop_dist);
            r_o_near  <= r_has && (r_last <= r_slow_dist);
            r_o_spike <= r_spike;
            r_o_acc   <= r_acc;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.distance_cm     = r_o_dist;
    assign o_out.obstacle_close  = r_o_close;
    assign o_out.obstacle_near   = r_o_near;
    assign o_out.spike_rejected  = r_o_spike;
    assign o_out.sample_accepted = r_o_acc;

endmodule

// ===== rtl/dsra_ctrl.sv =====
module dsra_ctrl
    import dsra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_sts.in_acc) n_state = ST_CONV;
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.take ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/distance_spike_reject_average_unit.sv =====
// Sequence: an input transaction passes the states CONV and UPD; a poll that is not
//   used or is a spike then goes to OUT, an accepted sample first waits in DIV for
//   the bit-serial divider that makes one quotient bit per cycle, then goes to OUT.
// The next poll is taken once OUT has loaded a result, even while that result waits.
// Reset (synchronous, active low) empties the window, clears the last value and
//   loads the threshold registers with their defaults.
module distance_spike_reject_average_unit
    import dsra_pkg::*;
#(
    parameter int WINDOW_DEPTH = DSRA_WINDOW_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsra_in_if.sink    i_in,
    dsra_out_if.source o_out,
    dsra_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;

    dsra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dsra_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

`ifndef SYNTHESIS
    a_acc_to_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.in_acc |=> cmd.conv)
        else $error("accepted transaction did not start conversion");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending result");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.sample_accepted |-> !o_out.spike_rejected)
        else $error("sample both accepted and rejected");

    a_none_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.distance_cm == DIST_NONE) |->
            !o_out.obstacle_close && !o_out.obstacle_near)
        else $error("obstacle flag without a reading");
`endif

endmodule

// ===== tb/dsra_report_checker.sv =====
module dsra_report_checker
    import dsra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dsra_in_if   i_poll,
    dsra_out_if  i_report,
    dsra_cfg_if  i_cfg,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_averaged,
    output int   o_spikes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN       = DSRA_WINDOW_DEPTH;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance_cm;
        logic                     obstacle_close;
        logic                     obstacle_near;
        logic                     spike_rejected;
        logic                     sample_accepted;
    } t_dist_report;

    logic [VAL_W-1:0] max_cm;
    logic [VAL_W-1:0] stop_cm;
    logic [VAL_W-1:0] slow_cm;
    logic [VAL_W-1:0] spike_cm;
    logic [VAL_W-1:0] ring [WIN];
    int               wr_pos;
    int               fill;
    logic [VAL_W-1:0] avg_cm;
    logic             seen;
    t_dist_report     due_reports [$];
    int               faults;
    int               averaged;
    int               spikes;
    int               checked;

    task automatic clear_filter();
        max_cm   = RST_MAX_DIST;
        stop_cm  = RST_STOP_DIST;
        slow_cm  = RST_SLOW_DIST;
        spike_cm = RST_SPIKE_LIM;
        for (int k = 0; k < WIN; k++) ring[k] = '0;
        wr_pos = 0;
        fill   = 0;
        avg_cm = '0;
        seen   = 1'b0;
        due_reports.delete();
    endtask

    function automatic t_dist_report filter_poll(logic rdy, logic tout,
                                                 logic [STAT_W-1:0] st,
                                                 logic [RAW_W-1:0] raw);
        t_dist_report     r;
        logic [RAW_W-1:0] quot;
        logic [VAL_W-1:0] cm;
        logic [VAL_W-1:0] jump;
        int unsigned      total;
        r = '0;
        if (rdy && !tout && st == '0) begin
            quot = raw / 10;
            cm   = (quot > max_cm) ? max_cm : quot[VAL_W-1:0];
            // no spike test until a nonzero value exists
            if (seen && avg_cm != '0) begin
                jump             = (cm > avg_cm) ? cm - avg_cm : avg_cm - cm;
                r.spike_rejected = jump > spike_cm;
            end
            if (!r.spike_rejected) begin
                ring[wr_pos] = cm;
                wr_pos       = (wr_pos + 1) % WIN;
                if (fill < WIN) fill++;
                total = 0;
                for (int k = 0; k < fill; k++) total += ring[k];
                avg_cm            = VAL_W'(total / fill);
                seen              = 1'b1;
                r.sample_accepted = 1'b1;
            end
        end
        if (seen) begin
            r.distance_cm    = {1'b0, avg_cm};
            r.obstacle_close = avg_cm <= stop_cm;
            r.obstacle_near  = avg_cm <= slow_cm;
        end else begin
            r.distance_cm = DIST_NONE;
        end
        return r;
    endfunction

    task automatic note_fault(string field, int want, int got);
        faults++;
        if (faults <= MAX_SHOWN) begin
            $display("[%0t] MISMATCH result %0d %s: expected %0d, got %0d",
                     $time, checked, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_dist_report got;
        t_dist_report want;
        if (!i_rst_n) begin
            clear_filter();
            faults   = 0;
            averaged = 0;
            spikes   = 0;
            checked  = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_MAX_DIST:  max_cm   = i_cfg.data;
                    CFG_STOP_DIST: stop_cm  = i_cfg.data;
                    CFG_SLOW_DIST: slow_cm  = i_cfg.data;
                    CFG_SPIKE_LIM: spike_cm = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_report.valid && i_report.ready) begin
                got.distance_cm     = i_report.distance_cm;
                got.obstacle_close  = i_report.obstacle_close;
                got.obstacle_near   = i_report.obstacle_near;
                got.spike_rejected  = i_report.spike_rejected;
                got.sample_accepted = i_report.sample_accepted;
                checked++;
                if (due_reports.size() == 0) begin
                    note_fault("unexpected transaction, distance_cm", 0, got.distance_cm);
                end else begin
                    want = due_reports.pop_front();
                    if (got.distance_cm !== want.distance_cm)
                        note_fault("distance_cm", want.distance_cm, got.distance_cm);
                    if (got.obstacle_close !== want.obstacle_close)
                        note_fault("obstacle_close", want.obstacle_close, got.obstacle_close);
                    if (got.obstacle_near !== want.obstacle_near)
                        note_fault("obstacle_near", want.obstacle_near, got.obstacle_near);
                    if (got.spike_rejected !== want.spike_rejected)
                        note_fault("spike_rejected", want.spike_rejected, got.spike_rejected);
                    if (got.sample_accepted !== want.sample_accepted)
                        note_fault("sample_accepted", want.sample_accepted,
                                   got.sample_accepted);
                end
            end
            if (i_poll.valid && i_poll.ready) begin
                want = filter_poll(i_poll.data_ready, i_poll.timed_out,
                                   i_poll.meas_status, i_poll.raw_mm);
                if (want.sample_accepted) averaged++;
                if (want.spike_rejected) spikes++;
                due_reports.push_back(want);
            end
        end
        o_mismatches  <= faults;
        o_outstanding <= due_reports.size();
        o_averaged    <= averaged;
        o_spikes      <= spikes;
    end

endmodule

// ===== tb/tb_distance_spike_reject_average_unit.sv =====
module tb_distance_spike_reject_average_unit
    import dsra_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   PHASES           = 10;
    localparam int                   PHASE_POLLS      = 150;
    localparam int                   SETTLE_CYCLES    = 24;
    localparam int                   QUIET_LIMIT      = 1000;
    localparam int                   VAL_MAX          = 1023;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 8'hFF;

    logic i_clk;
    logic i_rst_n;

    dsra_in_if  poll_ch ();
    dsra_out_if report_ch ();
    dsra_cfg_if cfg_ch ();

    int mismatches;
    int outstanding;
    int averaged;
    int spikes;

    int idle_pct;
    int stall_pct;
    int stall_left = 0;
    int quiet_cycles = 0;
    int walk_cm;
    int cur_max;
    int cur_spike;
    int polls;
    int cfg_writes;

    distance_spike_reject_average_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (poll_ch),
        .o_out   (report_ch),
        .i_cfg   (cfg_ch)
    );

    dsra_report_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_poll        (poll_ch),
        .i_report      (report_ch),
        .i_cfg         (cfg_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_averaged    (averaged),
        .o_spikes      (spikes)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            report_ch.ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(12);
            report_ch.ready <= 1'b0;
        end else begin
            report_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((poll_ch.valid && poll_ch.ready) || (report_ch.valid && report_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_poll(logic rdy, logic tout, logic [STAT_W-1:0] st,
                             logic [RAW_W-1:0] raw);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            poll_ch.valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
        poll_ch.valid        <= 1'b1;
        poll_ch.data_ready   <= rdy;
        poll_ch.timed_out    <= tout;
        poll_ch.meas_status  <= st;
        poll_ch.raw_mm       <= raw;
        @(posedge i_clk);
        while (!poll_ch.ready) @(posedge i_clk);
        polls++;
    endtask

    task automatic random_poll();
        int pick;
        int span;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_poll(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom),
                      16'($urandom));
        end else if (pick < 20) begin
            send_poll(1'b1, 1'b0, '0, 16'($urandom));
        end else begin
            span    = cur_spike + cur_spike / 4 + 2;
            walk_cm = walk_cm + int'($urandom_range(2 * span)) - span;
            if (walk_cm > cur_max + 3) walk_cm = cur_max + 3;
            if (walk_cm < 0) walk_cm = 0;
            send_poll(1'b1, 1'b0, '0, 16'(walk_cm * 10 + int'($urandom_range(9))));
        end
    endtask

    // drain every pending result, then let the block go quiet
    task automatic settle();
        poll_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic apply_settings(int mx, int stp, int slw, int spk);
        settle();
        cfg_write(CFG_MAX_DIST, VAL_W'(mx));
        if ($urandom_range(2) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                      VAL_W'($urandom));
        cfg_write(CFG_STOP_DIST, VAL_W'(stp));
        cfg_write(CFG_SLOW_DIST, VAL_W'(slw));
        cfg_write(CFG_SPIKE_LIM, VAL_W'(spk));
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        cur_max   = mx;
        cur_spike = spk;
    endtask

    function automatic int pick_setting();
        int roll;
        roll = $urandom_range(5);
        if (roll == 0) return 0;
        if (roll == 1) return VAL_MAX;
        return $urandom_range(VAL_MAX);
    endfunction

    initial begin
        i_rst_n              = 1'b0;
        poll_ch.valid        = 1'b0;
        poll_ch.data_ready   = 1'b0;
        poll_ch.timed_out    = 1'b0;
        poll_ch.meas_status  = '0;
        poll_ch.raw_mm       = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        polls                = 0;
        cfg_writes           = 0;
        idle_pct             = 20;
        stall_pct            = 10;
        cur_max              = RST_MAX_DIST;
        cur_spike            = RST_SPIKE_LIM;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: no reading yet, unusable polls, first readings
        send_poll(1'b0, 1'b0, '0, 16'd1000);
        send_poll(1'b1, 1'b1, '0, 16'd1000);
        send_poll(1'b1, 1'b0, 8'hFF, 16'd1000);
        send_poll(1'b1, 1'b0, 8'h01, 16'd1000);
        send_poll(1'b1, 1'b0, '0, 16'd0);
        send_poll(1'b1, 1'b0, '0, 16'hFFFF);
        send_poll(1'b1, 1'b0, '0, 16'hFFFF);
        send_poll(1'b1, 1'b0, '0, 16'd2509);
        send_poll(1'b1, 1'b0, '0, 16'd2679);
        repeat (6) send_poll(1'b1, 1'b0, '0, 16'd2300);

        // clamp to a small max with the close/near edges on it
        apply_settings(20, 20, 19, VAL_MAX);
        repeat (9) send_poll(1'b1, 1'b0, '0, 16'hFFFF);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                apply_settings(VAL_MAX, 0, VAL_MAX, 0);
            else if (p == 1)
                apply_settings(RST_MAX_DIST, RST_STOP_DIST, RST_SLOW_DIST, RST_SPIKE_LIM);
            else if (p == 2)
                apply_settings(0, VAL_MAX, 0, VAL_MAX);
            else
                apply_settings(pick_setting(), pick_setting(), pick_setting(),
                               pick_setting());
            idle_pct  = (p == PHASES - 1 || p % 3 == 1) ? 0 : 20;
            stall_pct = (p == PHASES - 1 || p % 4 == 2) ? 0 : 10;
            walk_cm   = $urandom_range(cur_max);
            repeat (PHASE_POLLS) random_poll();
        end

        settle();
        $display("Summary: %0d polls over %0d threshold settings (%0d register writes),",
                 polls, PHASES + 2, cfg_writes);
        $display("         %0d readings averaged, %0d spikes dropped", averaged, spikes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
